/* sv/slfr_pkg.sv */
// Shared types and constants for the sync/length frame receiver.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package slfr_pkg;

    // Default upper bound on the accepted payload length
    localparam int PAYLOAD_LIMIT_DEF = 512;

    // Depth of the queue between the parser and the result stage
    localparam int QUEUE_DEPTH = 2;

    // Length bytes are sent with this offset added
    localparam logic [7:0] LEN_OFFSET = 8'h20;

    // Reset values of the configuration registers
    localparam logic [7:0] SYNC_VALUE_RST  = 8'd1;
    localparam logic [9:0] MAX_PAYLOAD_RST = 10'd512;

    // Configuration register indexes
    localparam logic REG_SYNC_VALUE  = 1'b0;
    localparam logic REG_MAX_PAYLOAD = 1'b1;

    // Frame status codes
    localparam logic [1:0] ST_NONE = 2'd0;
    localparam logic [1:0] ST_OK   = 2'd1;
    localparam logic [1:0] ST_BAD  = 2'd2;

    // Classification of one received byte
    localparam logic [1:0] KIND_NONE    = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_CHECK   = 2'd2;

    // One classified byte, handed from the parser to the result stage
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic [7:0] check;
        logic [7:0] ftype;
        logic [9:0] length;
        logic [8:0] index;
    } slfr_item_t;

endpackage

`default_nettype wire

/* sv/sync_length_frame_receiver_unit.sv */
// Top level of the sync/length frame receiver: configuration registers
// and the parser, queue and result stage. Depends on slfr_pkg and slfr_*.
//
// Frame receiver taking one byte per transfer on the byte channel and giving
// exactly one result per byte on the result channel. It hunts for the sync
// byte, then reads a type byte and a little-endian length (each byte sent
// with 0x20 added), passes payload bytes out with their index, and reports
// the XOR checksum outcome on the final byte. Bytes are accepted at one per
// clock while the queue is not full, and the parser updates its state once
// per accepted byte. A result passes through the queue and then the output
// register before it is offered, and a two-entry queue lets the byte side
// keep going while a result waits for the sink.
// Configuration is over APB: sync_value at 0x0, max_payload at 0x4; write
// only while the block is idle.
`default_nettype none

module sync_length_frame_receiver_unit
    import slfr_pkg::*;
#(
    parameter int PAYLOAD_LIMIT = PAYLOAD_LIMIT_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // APB configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    // received bytes
    input  wire logic        byte_valid,
    output logic             byte_stall,
    input  wire logic [7:0]  rx_byte,
    // results
    output logic             result_valid,
    input  wire logic        result_stall,
    output logic [1:0]       frame_status,
    output logic [7:0]       frame_type,
    output logic [9:0]       frame_length,
    output logic             payload_valid,
    output logic [7:0]       payload_byte,
    output logic [8:0]       payload_index
);

    logic [7:0] sync_value_reg;
    logic [9:0] max_payload_reg;
    logic       reg_sel;
    logic       cfg_write;

    slfr_item_t front_item, head_item;
    logic       q_full, q_empty, q_pop, take;

    // Configuration registers
    assign pready    = 1'b1;
    assign reg_sel   = paddr[2];
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_value_reg  <= SYNC_VALUE_RST;
            max_payload_reg <= MAX_PAYLOAD_RST;
        end
        else if (cfg_write)
        begin
            if (reg_sel == REG_SYNC_VALUE)
                sync_value_reg <= pwdata[7:0];
            else
                max_payload_reg <= pwdata[9:0];
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_SYNC_VALUE:  prdata = {24'd0, sync_value_reg};
            REG_MAX_PAYLOAD: prdata = {22'd0, max_payload_reg};
            default:         prdata = '0;
        endcase
    end

    // Byte channel transfer
    assign byte_stall = q_full;
    assign take       = byte_valid && !q_full;

    slfr_front #(
        .PAYLOAD_LIMIT (PAYLOAD_LIMIT)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .sync_value  (sync_value_reg),
        .max_payload (max_payload_reg),
        .take        (take),
        .rx_byte     (rx_byte),
        .item        (front_item)
    );

    slfr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (take),
        .push_item (front_item),
        .pop       (q_pop),
        .head_item (head_item),
        .full      (q_full),
        .empty     (q_empty)
    );

    slfr_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .q_item        (head_item),
        .q_pop         (q_pop),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .frame_status  (frame_status),
        .frame_type    (frame_type),
        .frame_length  (frame_length),
        .payload_valid (payload_valid),
        .payload_byte  (payload_byte),
        .payload_index (payload_index)
    );

endmodule

`default_nettype wire

/* sv/slfr_front.sv */
// Parser front end: tracks the frame phase, runs the checksum and
// classifies each received byte. Depends on slfr_pkg.
`default_nettype none

module slfr_front
    import slfr_pkg::*;
#(
    parameter int PAYLOAD_LIMIT = PAYLOAD_LIMIT_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic [7:0] sync_value,
    input  wire logic [9:0] max_payload,
    input  wire logic       take,
    input  wire logic [7:0] rx_byte,
    output slfr_item_t      item
);

    localparam int LEN_W = $clog2(PAYLOAD_LIMIT + 1);

    // Phase codes
    localparam logic [2:0] PH_HUNT    = 3'd0;
    localparam logic [2:0] PH_TYPE    = 3'd1;
    localparam logic [2:0] PH_LEN     = 3'd2;
    localparam logic [2:0] PH_PAYLOAD = 3'd3;
    localparam logic [2:0] PH_CHECK   = 3'd4;

    logic [2:0]       phase_reg, phase_next;
    logic [7:0]       type_reg, type_next;
    logic [7:0]       low_reg, low_next;
    logic             step_reg, step_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [LEN_W-1:0] cnt_reg, cnt_next;
    logic [7:0]       check_reg, check_next;

    logic [7:0]       lo_dec, hi_dec;
    logic [15:0]      len_rx;
    logic             len_over;
    logic [LEN_W-1:0] cnt_inc;
    logic [15:0]      len_wide, cnt_wide;

    // Length decode and limit check
    assign lo_dec   = low_reg - LEN_OFFSET;
    assign hi_dec   = rx_byte - LEN_OFFSET;
    assign len_rx   = {hi_dec, lo_dec};
    assign len_over = (len_rx > 16'(max_payload)) || (len_rx > 16'(PAYLOAD_LIMIT));
    assign cnt_inc  = cnt_reg + LEN_W'(1);
    assign len_wide = 16'(len_reg);
    assign cnt_wide = 16'(cnt_reg);

    // Next state and classification
    always_comb
    begin
        phase_next = phase_reg;
        type_next  = type_reg;
        low_next   = low_reg;
        step_next  = step_reg;
        len_next   = len_reg;
        cnt_next   = cnt_reg;
        check_next = check_reg;
        item       = '0;
        item.kind  = KIND_NONE;

        case (phase_reg)
            PH_TYPE:
            begin
                type_next  = rx_byte;
                check_next = rx_byte;
                step_next  = 1'b0;
                cnt_next   = '0;
                phase_next = PH_LEN;
            end
            PH_LEN:
            begin
                if (!step_reg)
                begin
                    low_next  = rx_byte;
                    step_next = 1'b1;
                end
                else
                begin
                    len_next   = len_rx[LEN_W-1:0];
                    step_next  = 1'b0;
                    cnt_next   = '0;
                    check_next = check_reg ^ lo_dec ^ hi_dec;
                    if (len_rx == 16'd0)
                        phase_next = PH_CHECK;
                    else if (len_over)
                        phase_next = PH_HUNT;
                    else
                        phase_next = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD:
            begin
                item.kind  = KIND_PAYLOAD;
                item.data  = rx_byte;
                item.index = cnt_wide[8:0];
                check_next = check_reg ^ rx_byte;
                cnt_next   = cnt_inc;
                if (cnt_inc == len_reg)
                    phase_next = PH_CHECK;
            end
            PH_CHECK:
            begin
                item.kind   = KIND_CHECK;
                item.data   = rx_byte;
                item.check  = check_reg;
                item.ftype  = type_reg;
                item.length = len_wide[9:0];
                phase_next  = PH_HUNT;
            end
            default:
            begin
                // hunting, and any unused code
                phase_next = (rx_byte == sync_value) ? PH_TYPE : PH_HUNT;
            end
        endcase
    end

    // State registers, updated once per accepted byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            type_reg  <= '0;
            low_reg   <= '0;
            step_reg  <= 1'b0;
            len_reg   <= '0;
            cnt_reg   <= '0;
            check_reg <= '0;
        end
        else if (take)
        begin
            phase_reg <= phase_next;
            type_reg  <= type_next;
            low_reg   <= low_next;
            step_reg  <= step_next;
            len_reg   <= len_next;
            cnt_reg   <= cnt_next;
            check_reg <= check_next;
        end
    end

endmodule

`default_nettype wire

/* sv/slfr_queue.sv */
// Short FIFO of classified bytes between parser and result stage.
// Depends on slfr_pkg.
`default_nettype none

module slfr_queue
    import slfr_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  wire slfr_item_t push_item,
    input  wire logic       pop,
    output slfr_item_t      head_item,
    output logic            full,
    output logic            empty
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    slfr_item_t       mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty     = (count_reg == '0);
    assign head_item = mem[rd_ptr_reg];

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_item;
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : wr_ptr_reg + PTR_W'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : rd_ptr_reg + PTR_W'(1);
            if (push && !pop)
                count_reg <= count_reg + CNT_W'(1);
            else if (pop && !push)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

endmodule

`default_nettype wire

/* sv/slfr_back.sv */
// Result stage: compares the checksum, forms the result fields and
// holds them in the output register. Depends on slfr_pkg.
`default_nettype none

module slfr_back
    import slfr_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       q_empty,
    input  wire slfr_item_t q_item,
    output logic            q_pop,
    output logic            result_valid,
    input  wire logic       result_stall,
    output logic [1:0]      frame_status,
    output logic [7:0]      frame_type,
    output logic [9:0]      frame_length,
    output logic            payload_valid,
    output logic [7:0]      payload_byte,
    output logic [8:0]      payload_index
);

    logic       valid_reg;
    logic [1:0] status_reg, status_next;
    logic [7:0] type_reg, type_next;
    logic [9:0] length_reg, length_next;
    logic       pvalid_reg, pvalid_next;
    logic [7:0] pbyte_reg, pbyte_next;
    logic [8:0] pindex_reg, pindex_next;

    // Load when the output register is free or its transfer completes
    assign q_pop = !q_empty && (!valid_reg || !result_stall);

    // Build result fields from the classified byte
    always_comb
    begin
        status_next = ST_NONE;
        type_next   = '0;
        length_next = '0;
        pvalid_next = 1'b0;
        pbyte_next  = '0;
        pindex_next = '0;
        case (q_item.kind)
            KIND_PAYLOAD:
            begin
                pvalid_next = 1'b1;
                pbyte_next  = q_item.data;
                pindex_next = q_item.index;
            end
            KIND_CHECK:
            begin
                status_next = (q_item.data == q_item.check) ? ST_OK : ST_BAD;
                type_next   = q_item.ftype;
                length_next = q_item.length;
            end
            default:
            begin
                status_next = ST_NONE;
            end
        endcase
    end

    // Output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (q_pop)
            valid_reg <= 1'b1;
        else if (!result_stall)
            valid_reg <= 1'b0;
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            status_reg <= status_next;
            type_reg   <= type_next;
            length_reg <= length_next;
            pvalid_reg <= pvalid_next;
            pbyte_reg  <= pbyte_next;
            pindex_reg <= pindex_next;
        end
    end

    assign result_valid  = valid_reg;
    assign frame_status  = status_reg;
    assign frame_type    = type_reg;
    assign frame_length  = length_reg;
    assign payload_valid = pvalid_reg;
    assign payload_byte  = pbyte_reg;
    assign payload_index = pindex_reg;

endmodule

`default_nettype wire

/* sv/slfr_checker.sv */
// Port-level checks for the frame receiver, bound to the top level.
// Depends on slfr_pkg and sync_length_frame_receiver_unit.
`default_nettype none

module slfr_checker
    import slfr_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       result_valid,
    input wire logic       result_stall,
    input wire logic [1:0] frame_status,
    input wire logic [7:0] frame_type,
    input wire logic [9:0] frame_length,
    input wire logic       payload_valid,
    input wire logic [7:0] payload_byte,
    input wire logic [8:0] payload_index
);

    // A stalled result stays offered
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result dropped while stalled");

    // A payload byte never carries a frame outcome
    a_payload_no_status: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && payload_valid |-> frame_status == ST_NONE)
        else $error("payload byte with frame status");

    // No outcome means no frame fields
    a_idle_fields: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && frame_status == ST_NONE
            |-> frame_type == 8'd0 && frame_length == 10'd0)
        else $error("frame fields without status");

    // Payload fields are clear when no payload byte is shown
    a_no_payload_fields: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !payload_valid |-> payload_byte == 8'd0 && payload_index == 9'd0)
        else $error("payload fields without payload");

endmodule

bind sync_length_frame_receiver_unit slfr_checker u_slfr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .frame_status  (frame_status),
    .frame_type    (frame_type),
    .frame_length  (frame_length),
    .payload_valid (payload_valid),
    .payload_byte  (payload_byte),
    .payload_index (payload_index)
);

`default_nettype wire

/* sim/tb_sync_length_frame_receiver_unit.sv */
// Self-checking testbench for sync_length_frame_receiver_unit: byte stimulus,
// APB configuration, a byte-level frame predictor and a result scoreboard.
// Depends on slfr_pkg and the RTL of the receiver.

module tb_sync_length_frame_receiver_unit;

    import slfr_pkg::*;

    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int RANDOM_ITEMS  = 840;
    localparam int MAX_PRINTS    = 40;

    // receiver phases as tracked by the predictor
    typedef enum logic [2:0] {
        HUNT_SYNC,
        GET_TYPE,
        GET_LEN,
        GET_PAYLOAD,
        GET_CHECK
    } rx_phase_t;

    // one result transfer
    typedef struct {
        logic [1:0] status;
        logic [7:0] ftype;
        logic [9:0] flen;
        logic       pvalid;
        logic [7:0] pbyte;
        logic [8:0] pidx;
    } frame_result_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        byte_valid;
    logic        byte_stall;
    logic [7:0]  rx_byte;
    logic        result_valid;
    logic        result_stall;
    logic [1:0]  frame_status;
    logic [7:0]  frame_type;
    logic [9:0]  frame_length;
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic [8:0]  payload_index;

    // predictor copy of the configuration and receiver state
    logic [7:0]  sync_cfg    = SYNC_VALUE_RST;
    logic [9:0]  max_cfg     = MAX_PAYLOAD_RST;
    rx_phase_t   rx_phase    = HUNT_SYNC;
    logic [7:0]  rx_type     = '0;
    logic [7:0]  len_lo_raw  = '0;
    logic        len_second  = 1'b0;
    logic [15:0] rx_len      = '0;
    logic [15:0] pay_count   = '0;
    logic [7:0]  run_xor     = '0;

    frame_result_t expected_results[$];
    frame_result_t want_res;

    int mismatches = 0;
    int bytes_sent = 0;
    int cycles     = 0;
    int idle_level = 0;

    sync_length_frame_receiver_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .byte_valid    (byte_valid),
        .byte_stall    (byte_stall),
        .rx_byte       (rx_byte),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .frame_status  (frame_status),
        .frame_type    (frame_type),
        .frame_length  (frame_length),
        .payload_valid (payload_valid),
        .payload_byte  (payload_byte),
        .payload_index (payload_index)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // run guard
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_sync_length_frame_receiver_unit failed");
            $finish;
        end
    end

    // largest payload the receiver takes, saturated at the build limit
    function automatic logic [15:0] length_ceiling();
        if (max_cfg > PAYLOAD_LIMIT_DEF)
            return 16'(PAYLOAD_LIMIT_DEF);
        return 16'(max_cfg);
    endfunction

    // advance the predicted receiver by one byte and give its result
    function automatic frame_result_t frame_predict(input logic [7:0] b);
        frame_result_t r;
        logic [7:0] lo;
        logic [7:0] hi;
        r = '{ST_NONE, 8'd0, 10'd0, 1'b0, 8'd0, 9'd0};
        case (rx_phase)
            GET_TYPE:
            begin
                rx_type    = b;
                run_xor    = b;
                len_second = 1'b0;
                pay_count  = '0;
                rx_phase   = GET_LEN;
            end
            GET_LEN:
            begin
                if (!len_second)
                begin
                    len_lo_raw = b;
                    len_second = 1'b1;
                end
                else
                begin
                    lo         = len_lo_raw - LEN_OFFSET;
                    hi         = b - LEN_OFFSET;
                    rx_len     = {hi, lo};
                    len_second = 1'b0;
                    pay_count  = '0;
                    run_xor    = run_xor ^ lo ^ hi;
                    if (rx_len == 0)
                        rx_phase = GET_CHECK;
                    else if (rx_len > length_ceiling())
                        rx_phase = HUNT_SYNC;
                    else
                        rx_phase = GET_PAYLOAD;
                end
            end
            GET_PAYLOAD:
            begin
                r.pvalid  = 1'b1;
                r.pbyte   = b;
                r.pidx    = pay_count[8:0];
                run_xor   = run_xor ^ b;
                pay_count = pay_count + 1;
                if (pay_count >= rx_len)
                    rx_phase = GET_CHECK;
            end
            GET_CHECK:
            begin
                r.status = (b == run_xor) ? ST_OK : ST_BAD;
                r.ftype  = rx_type;
                r.flen   = rx_len[9:0];
                rx_phase = HUNT_SYNC;
            end
            default:
                rx_phase = (b == sync_cfg) ? GET_TYPE : HUNT_SYNC;
        endcase
        return r;
    endfunction

    // one line per mismatch, printing capped
    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatches < MAX_PRINTS)
            $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    // scoreboard: each result transfer against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_results.size() == 0)
                report_mismatch("result with nothing pending", frame_status, 0);
            else
            begin
                want_res = expected_results.pop_front();
                if (frame_status !== want_res.status)
                    report_mismatch("frame_status", frame_status, want_res.status);
                if (frame_type !== want_res.ftype)
                    report_mismatch("frame_type", frame_type, want_res.ftype);
                if (frame_length !== want_res.flen)
                    report_mismatch("frame_length", frame_length, want_res.flen);
                if (payload_valid !== want_res.pvalid)
                    report_mismatch("payload_valid", payload_valid, want_res.pvalid);
                if (payload_byte !== want_res.pbyte)
                    report_mismatch("payload_byte", payload_byte, want_res.pbyte);
                if (payload_index !== want_res.pidx)
                    report_mismatch("payload_index", payload_index, want_res.pidx);
            end
        end
    end

    // result-side back-pressure: runs of stall, mostly short, a few long
    initial
    begin : result_backpressure
        int hold;
        hold         = 0;
        result_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold > 0)
                hold--;
            else if (idle_level == 0)
                result_stall <= 1'b0;
            else if ($urandom_range(0, 99) < (idle_level == 1 ? 20 : 50))
            begin
                result_stall <= 1'b1;
                hold = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                   : $urandom_range(0, 2);
            end
            else
            begin
                result_stall <= 1'b0;
                hold = $urandom_range(0, 3);
            end
        end
    end

    // gap before the next byte transfer
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (idle_level == 0 || r < (idle_level == 1 ? 70 : 40))
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // one byte transfer; prediction taken at the accepting edge
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            byte_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        byte_valid <= 1'b1;
        rx_byte    <= b;
        do
            @(posedge clk);
        while (byte_stall);
        expected_results.push_back(frame_predict(b));
        bytes_sent++;
    endtask

    task automatic bytes_idle();
        @(negedge clk);
        byte_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // APB write: setup then access phase
    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // reconfigure only once the receiver has gone quiet
    task automatic write_config(input logic [7:0] sync_v, input logic [9:0] max_v);
        bytes_idle();
        wait_drained();
        apb_write({REG_SYNC_VALUE, 2'b00}, 32'(sync_v));
        sync_cfg = sync_v;
        apb_write({REG_MAX_PAYLOAD, 2'b00}, 32'(max_v));
        max_cfg = max_v;
    endtask

    // whole frame with random payload; header only when it is overlong
    task automatic send_frame(input logic [7:0] ftype, input logic [15:0] flen,
                              input bit corrupt);
        logic [7:0] csum;
        logic [7:0] d;
        csum = ftype ^ flen[7:0] ^ flen[15:8];
        send_byte(sync_cfg);
        send_byte(ftype);
        send_byte(flen[7:0] + LEN_OFFSET);
        send_byte(flen[15:8] + LEN_OFFSET);
        if (flen <= length_ceiling() || flen == 0)
        begin
            for (int i = 0; i < int'(flen); i++)
            begin
                d    = 8'($urandom);
                csum = csum ^ d;
                send_byte(d);
            end
            if (corrupt)
                csum = csum ^ 8'($urandom_range(1, 255));
            send_byte(csum);
        end
    endtask

    // defaults after reset: noise, empty frame, sync inside payload, bad check, drop
    task automatic test_basic_frames();
        idle_level = 0;
        send_byte(8'h00);
        send_byte(8'hFF);
        send_frame(8'h00, 16'd0, 1'b0);
        // payload holds the sync byte; check = FF^02^00^01^FF
        send_byte(sync_cfg);
        send_byte(8'hFF);
        send_byte(8'h22);
        send_byte(8'h20);
        send_byte(sync_cfg);
        send_byte(8'hFF);
        send_byte(8'h03);
        send_frame(8'hC3, 16'd1, 1'b1);
        send_frame(8'h3C, 16'd600, 1'b0);
        send_byte(8'h55);
    endtask

    // zero limit: only empty frames pass
    task automatic test_zero_limit();
        idle_level = 1;
        write_config(8'h00, 10'd0);
        send_frame(8'h5A, 16'd0, 1'b0);
        send_frame(8'hA5, 16'd1, 1'b0);
        send_byte(8'h33);
        send_frame(8'hFF, 16'd0, 1'b1);
    endtask

    // full-size frame and one byte beyond it
    task automatic test_full_length();
        idle_level = 2;
        write_config(8'hFF, 10'd512);
        send_frame(8'h80, 16'd512, 1'b0);
        send_frame(8'h01, 16'd513, 1'b0);
        send_frame(8'h7F, 16'd3, 1'b0);
    endtask

    // max_payload above the build limit saturates
    task automatic test_saturated_limit();
        idle_level = 1;
        write_config(8'h7E, 10'h3FF);
        send_frame(8'h11, 16'd513, 1'b0);
        send_frame(8'h22, 16'hFFFF, 1'b0);
        send_frame(8'h33, 16'd5, 1'b1);
    endtask

    // small limit: edge length accepted, one more dropped
    task automatic test_small_limit();
        idle_level = 0;
        write_config(8'($urandom), 10'd7);
        send_frame(8'h44, 16'd7, 1'b0);
        send_frame(8'h45, 16'd8, 1'b0);
        send_frame(8'h46, 16'd2, 1'b0);
    endtask

    // mostly well-formed frames, with drops, noise and truncated headers
    task automatic test_random_traffic();
        int stop_at;
        int phase_end;
        int r;
        int lim;
        logic [9:0] max_v;
        stop_at = bytes_sent + RANDOM_ITEMS;
        while (bytes_sent < stop_at)
        begin
            r = $urandom_range(0, 99);
            if (r < 12)
                max_v = 10'd0;
            else if (r < 27)
                max_v = 10'd512;
            else if (r < 37)
                max_v = 10'($urandom_range(513, 1023));
            else
                max_v = 10'($urandom_range(1, 40));
            idle_level = $urandom_range(0, 2);
            write_config(8'($urandom), max_v);
            phase_end = bytes_sent + $urandom_range(120, 250);
            while (bytes_sent < phase_end && bytes_sent < stop_at)
            begin
                lim = int'(length_ceiling());
                r   = $urandom_range(0, 99);
                if (r < 72)
                begin
                    if ($urandom_range(0, 49) == 0)
                        send_frame(8'($urandom), 16'($urandom_range(0, lim)),
                                   $urandom_range(0, 5) == 0);
                    else
                        send_frame(8'($urandom),
                                   16'($urandom_range(0, lim < 16 ? lim : 16)),
                                   $urandom_range(0, 5) == 0);
                end
                else if (r < 82)
                    send_frame(8'($urandom), 16'($urandom_range(lim + 1, 65535)), 1'b0);
                else if (r < 91)
                    repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
                else
                begin
                    send_byte(sync_cfg);
                    repeat ($urandom_range(0, 3)) send_byte(8'($urandom));
                end
            end
        end
    endtask

    // main sequence
    initial
    begin
        rst_n      = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        byte_valid = 1'b0;
        rx_byte    = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_basic_frames();
        test_zero_limit();
        test_full_length();
        test_saturated_limit();
        test_small_limit();
        test_random_traffic();

        bytes_idle();
        wait_drained();
        if (mismatches == 0)
            $display("tb_sync_length_frame_receiver_unit passed");
        else
            $display("tb_sync_length_frame_receiver_unit failed");
        $finish;
    end

endmodule
